### rtl/rv32x_pkg.sv
// types and constants shared by the execute core
package rv32x_pkg;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] instruction;
		logic [31:0] value;
		logic        perm_read;
		logic        perm_write;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [31:0] mem_address;
		logic [1:0]  access_size;
		logic [31:0] store_data;
		logic [2:0]  fault_code;
		logic [31:0] pc_now;
		logic        reg_written;
		logic [4:0]  reg_index;
		logic [31:0] reg_value;
	} out_word_t;

	// architectural state seen by the execute logic
	typedef struct packed {
		logic [31:0] pc;
		logic        load_pending;
		logic [4:0]  pending_dest;
		logic [1:0]  pending_size;
		logic        pending_signed;
		logic        halted;
		logic [2:0]  halt_code;
	} core_state_t;

	// register file write request
	typedef struct packed {
		logic        en;
		logic [4:0]  idx;
		logic [31:0] data;
	} rf_write_t;

	localparam logic [1:0] ACT_EXEC     = 2'd0;
	localparam logic [1:0] ACT_LOAD     = 2'd1;
	localparam logic [1:0] ACT_SET_PC   = 2'd2;
	localparam logic [1:0] ACT_RESERVED = 2'd3;

	localparam logic [2:0] KIND_DONE    = 3'd0;
	localparam logic [2:0] KIND_LOAD    = 3'd1;
	localparam logic [2:0] KIND_STORE   = 3'd2;
	localparam logic [2:0] KIND_FAULT   = 3'd3;
	localparam logic [2:0] KIND_IGNORED = 3'd4;

	localparam logic [2:0] FLT_NONE   = 3'd0;
	localparam logic [2:0] FLT_OPCODE = 3'd1;
	localparam logic [2:0] FLT_FUNCT3 = 3'd2;
	localparam logic [2:0] FLT_FUNCT7 = 3'd3;
	localparam logic [2:0] FLT_NO_RD  = 3'd4;
	localparam logic [2:0] FLT_NO_WR  = 3'd5;

	localparam logic [6:0] OP_REG    = 7'b0110011;
	localparam logic [6:0] OP_IMM    = 7'b0010011;
	localparam logic [6:0] OP_BRANCH = 7'b1100011;
	localparam logic [6:0] OP_STORE  = 7'b0100011;
	localparam logic [6:0] OP_LOAD   = 7'b0000011;
	localparam logic [6:0] OP_JAL    = 7'b1101111;
	localparam logic [6:0] OP_JALR   = 7'b1100111;
	localparam logic [6:0] OP_LUI    = 7'b0110111;
	localparam logic [6:0] OP_AUIPC  = 7'b0010111;

	localparam logic [6:0] F7_ALT = 7'h20;

	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_HALF = 2'd1;

	function automatic logic [31:0] alu(input logic [2:0] f3, input logic alt,
			input logic [31:0] a, input logic [31:0] b);
		logic [4:0] sh;
		sh = b[4:0];
		case (f3)
			3'd0:    alu = alt ? a - b : a + b;
			3'd1:    alu = a << sh;
			3'd2:    alu = {31'd0, $signed(a) < $signed(b)};
			3'd3:    alu = {31'd0, a < b};
			3'd4:    alu = a ^ b;
			3'd5:    alu = alt ? 32'($signed(a) >>> sh) : a >> sh;
			3'd6:    alu = a | b;
			default: alu = a & b;
		endcase
	endfunction

endpackage

### rtl/rv32i_integer_execute_core.sv
// the result word is registered and appears in the cycle after its input word is taken
// throughput: one word per cycle while no result is held; the register file and state update in that cycle
// the output register frees whenever the result is taken, so input is blocked only by a held result
// reset clears the pc, the register file, pending load and halt state
module rv32i_integer_execute_core #(
	parameter int REGISTER_COUNT = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  rv32x_pkg::in_word_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output rv32x_pkg::out_word_t out_data
);

	logic [31:0]            rf_q [REGISTER_COUNT];
	rv32x_pkg::core_state_t st_q, st_next;
	rv32x_pkg::rf_write_t   wr;
	rv32x_pkg::out_word_t   res;
	logic [31:0]            rs1_val, rs2_val;
	logic                   take_in;

	function automatic logic idx_ok(input logic [4:0] i);
		idx_ok = i != 5'd0 && 32'(i) < 32'(REGISTER_COUNT);
	endfunction

	assign rs1_val = idx_ok(in_data.instruction[19:15]) ?
		rf_q[in_data.instruction[19:15]] : 32'd0;
	assign rs2_val = idx_ok(in_data.instruction[24:20]) ?
		rf_q[in_data.instruction[24:20]] : 32'd0;

	assign in_ready = !out_valid || out_ready;
	assign take_in  = in_valid && in_ready;

	rv32x_exec u_exec (
		.item    (in_data),
		.st      (st_q),
		.rs1_val (rs1_val),
		.rs2_val (rs2_val),
		.rd_ok   (idx_ok(in_data.instruction[11:7])),
		.pd_ok   (idx_ok(st_q.pending_dest)),
		.st_next (st_next),
		.wr      (wr),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= '0;
			out_valid <= 1'b0;
			for (int i = 0; i < REGISTER_COUNT; i++) rf_q[i] <= '0;
		end else begin
			if (take_in) begin
				st_q <= st_next;
				if (wr.en) rf_q[wr.idx] <= wr.data;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) out_data <= res;
	end

endmodule

### rtl/rv32x_exec.sv
// combinational execute logic for one item
module rv32x_exec (
	input  rv32x_pkg::in_word_t    item,
	input  rv32x_pkg::core_state_t st,
	input  logic [31:0]            rs1_val,
	input  logic [31:0]            rs2_val,
	input  logic                   rd_ok,
	input  logic                   pd_ok,
	output rv32x_pkg::core_state_t st_next,
	output rv32x_pkg::rf_write_t   wr,
	output rv32x_pkg::out_word_t   res
);

	logic [31:0] ins;
	logic [6:0]  op;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [31:0] immi, imms, immb, immj, immu, pc4;
	logic        take;
	logic [2:0]  flt;
	logic [31:0] ld_v;

	assign ins  = item.instruction;
	assign op   = ins[6:0];
	assign f3   = ins[14:12];
	assign f7   = ins[31:25];
	assign immi = {{20{ins[31]}}, ins[31:20]};
	assign imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
	assign immb = {{20{ins[31]}}, ins[7], ins[30:25], ins[11:8], 1'b0};
	assign immj = {{12{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};
	assign immu = {ins[31:12], 12'd0};
	assign pc4  = st.pc + 32'd4;

	always_comb begin
		case (f3)
			3'd0:    take = rs1_val == rs2_val;
			3'd1:    take = rs1_val != rs2_val;
			3'd4:    take = $signed(rs1_val) < $signed(rs2_val);
			3'd5:    take = $signed(rs1_val) >= $signed(rs2_val);
			3'd6:    take = rs1_val < rs2_val;
			default: take = rs1_val >= rs2_val;
		endcase
	end

	always_comb begin
		case (st.pending_size)
			rv32x_pkg::SIZE_BYTE: ld_v = st.pending_signed ?
				{{24{item.value[7]}}, item.value[7:0]} : {24'd0, item.value[7:0]};
			rv32x_pkg::SIZE_HALF: ld_v = st.pending_signed ?
				{{16{item.value[15]}}, item.value[15:0]} : {16'd0, item.value[15:0]};
			default: ld_v = item.value;
		endcase
	end

	always_comb begin
		st_next = st;
		wr      = '0;
		res     = '0;
		flt     = rv32x_pkg::FLT_NONE;
		wr.idx  = ins[11:7];
		if (item.action == rv32x_pkg::ACT_SET_PC) begin
			st_next.pc           = item.value;
			st_next.halted       = 1'b0;
			st_next.halt_code    = rv32x_pkg::FLT_NONE;
			st_next.load_pending = 1'b0;
		end else if (item.action == rv32x_pkg::ACT_RESERVED) begin
			res.result_kind = rv32x_pkg::KIND_IGNORED;
		end else if (st.halted) begin
			res.result_kind = rv32x_pkg::KIND_IGNORED;
			res.fault_code  = st.halt_code;
		end else if (item.action == rv32x_pkg::ACT_LOAD) begin
			if (!st.load_pending) begin
				res.result_kind = rv32x_pkg::KIND_IGNORED;
			end else begin
				res.access_size      = st.pending_size;
				wr.en                = pd_ok;
				wr.idx               = st.pending_dest;
				wr.data              = ld_v;
				st_next.load_pending = 1'b0;
			end
		end else if (st.load_pending) begin
			res.result_kind = rv32x_pkg::KIND_IGNORED;
		end else begin
			case (op)
				rv32x_pkg::OP_REG: begin
					if (f7 != 7'd0 && !(f7 == rv32x_pkg::F7_ALT && (f3 == 3'd0 || f3 == 3'd5)))
						flt = rv32x_pkg::FLT_FUNCT7;
					wr.data = rv32x_pkg::alu(f3, f7 == rv32x_pkg::F7_ALT, rs1_val, rs2_val);
					wr.en = rd_ok;
					st_next.pc = pc4;
				end
				rv32x_pkg::OP_IMM: begin
					if ((f3 == 3'd1 && f7 != 7'd0) ||
							(f3 == 3'd5 && f7 != 7'd0 && f7 != rv32x_pkg::F7_ALT))
						flt = rv32x_pkg::FLT_FUNCT7;
					wr.data = rv32x_pkg::alu(f3, f3 == 3'd5 && f7 == rv32x_pkg::F7_ALT,
						rs1_val, immi);
					wr.en = rd_ok;
					st_next.pc = pc4;
				end
				rv32x_pkg::OP_LUI: begin
					wr.data = immu;
					wr.en = rd_ok;
					st_next.pc = pc4;
				end
				rv32x_pkg::OP_AUIPC: begin
					wr.data = st.pc + immu;
					wr.en = rd_ok;
					st_next.pc = pc4;
				end
				rv32x_pkg::OP_BRANCH: begin
					if (f3 == 3'd2 || f3 == 3'd3) flt = rv32x_pkg::FLT_FUNCT3;
					st_next.pc = take ? st.pc + immb : pc4;
				end
				rv32x_pkg::OP_JAL: begin
					wr.data = pc4;
					wr.en = rd_ok;
					st_next.pc = st.pc + immj;
				end
				rv32x_pkg::OP_JALR: begin
					if (f3 != 3'd0) flt = rv32x_pkg::FLT_FUNCT3;
					wr.data = pc4;
					wr.en = rd_ok;
					st_next.pc = (rs1_val + immi) & ~32'h1;
				end
				rv32x_pkg::OP_LOAD: begin
					if (!item.perm_read) flt = rv32x_pkg::FLT_NO_RD;
					else if (f3 == 3'd3 || f3 > 3'd5) flt = rv32x_pkg::FLT_FUNCT3;
					st_next.load_pending   = 1'b1;
					st_next.pending_dest   = ins[11:7];
					st_next.pending_size   = f3[1:0];
					st_next.pending_signed = ~f3[2];
					res.result_kind = rv32x_pkg::KIND_LOAD;
					res.mem_address = rs1_val + immi;
					res.access_size = f3[1:0];
					st_next.pc = pc4;
				end
				rv32x_pkg::OP_STORE: begin
					if (!item.perm_write) flt = rv32x_pkg::FLT_NO_WR;
					else if (f3 > 3'd2) flt = rv32x_pkg::FLT_FUNCT3;
					res.result_kind = rv32x_pkg::KIND_STORE;
					res.mem_address = rs1_val + imms;
					res.access_size = f3[1:0];
					res.store_data  = rs2_val;
					st_next.pc = pc4;
				end
				default: flt = rv32x_pkg::FLT_OPCODE;
			endcase
			if (flt != rv32x_pkg::FLT_NONE) begin
				st_next           = st;
				st_next.halted    = 1'b1;
				st_next.halt_code = flt;
				wr.en             = 1'b0;
				res               = '0;
				res.result_kind   = rv32x_pkg::KIND_FAULT;
				res.fault_code    = flt;
			end
		end
		res.pc_now      = st_next.pc;
		res.reg_written = wr.en;
		if (wr.en) begin
			res.reg_index = wr.idx;
			res.reg_value = wr.data;
		end
	end

endmodule

### rtl/rv32x_checker.sv
// port-level checks for the execute core
module rv32x_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input rv32x_pkg::in_word_t  in_data,
	input logic                 out_valid,
	input logic                 out_ready,
	input rv32x_pkg::out_word_t out_data
);

	// a taken word always yields a result next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid) else $error("no result word");

	// set_pc lands its value in the pc
	a_setpc: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.action == rv32x_pkg::ACT_SET_PC |=>
		out_data.pc_now == $past(in_data.value) &&
		out_data.result_kind == rv32x_pkg::KIND_DONE) else $error("set_pc");

	// a fault never writes a register
	a_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.result_kind == rv32x_pkg::KIND_FAULT |->
		!out_data.reg_written && out_data.fault_code != rv32x_pkg::FLT_NONE)
		else $error("fault wrote");

	// x0 is never reported written
	a_x0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.reg_written |-> out_data.reg_index != 5'd0)
		else $error("x0 written");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("drop");

endmodule

bind rv32i_integer_execute_core rv32x_checker u_checker (.*);

### tb/tb_rv32i_integer_execute_core.sv
// self-checking testbench for the rv32i integer execute core
`timescale 1ns / 100ps

module tb_rv32i_integer_execute_core;

	localparam int REG_N = 32;
	localparam int STALL_LEN = 80;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct {
		rv32x_pkg::in_word_t w;
		bit                  drain;
	} stim_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	rv32x_pkg::in_word_t  in_data;
	logic                 out_valid;
	logic                 out_ready;
	rv32x_pkg::out_word_t out_data;

	rv32i_integer_execute_core #(.REGISTER_COUNT(REG_N)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// architectural shadow state
	logic [31:0] regs [0:31];
	logic [31:0] pc_q = '0;
	logic        ld_busy = 0;
	logic [4:0]  ld_dest = '0;
	logic [1:0]  ld_size = '0;
	logic        ld_sext = 0;
	logic        halted_q = 0;
	logic [2:0]  halt_q = '0;
	rv32x_pkg::out_word_t pred;

	stim_t                stim_q[$];
	rv32x_pkg::out_word_t exp_q[$];
	int        errors = 0;
	int        n_words = 0, n_loads = 0, n_stores = 0, n_faults = 0, n_ignored = 0;
	bit        took_in = 0;
	bit        idle_on = 1;
	int        in_gap = 0, out_gap = 0, stall_left = 0;
	bit        did_stall = 0;
	int        quiet = 0;

	initial begin
		for (int i = 0; i < 32; i++) regs[i] = '0;
	end

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic logic [31:0] get_reg(logic [4:0] i);
		return (i == 0 || i >= REG_N) ? 32'd0 : regs[i];
	endfunction

	function automatic void put_reg(logic [4:0] i, logic [31:0] v);
		if (i == 0 || i >= REG_N) return;
		regs[i] = v;
		pred.reg_written = 1;
		pred.reg_index = i;
		pred.reg_value = v;
	endfunction

	function automatic logic [31:0] alu_calc(logic [2:0] f3, logic alt, logic [31:0] a,
			logic [31:0] b);
		case (f3)
			3'd0: return alt ? a - b : a + b;
			3'd1: return a << b[4:0];
			3'd2: return {31'd0, $signed(a) < $signed(b)};
			3'd3: return {31'd0, a < b};
			3'd4: return a ^ b;
			3'd5: return alt ? $unsigned($signed(a) >>> b[4:0]) : a >> b[4:0];
			3'd6: return a | b;
			default: return a & b;
		endcase
	endfunction

	// returns a fault code, fills pred on success
	function automatic logic [2:0] run_instr(rv32x_pkg::in_word_t w);
		logic [31:0] ins, a, b, immi, imm, addr;
		logic [6:0]  op, f7;
		logic [4:0]  rd;
		logic [2:0]  f3;
		logic        take;
		ins = w.instruction;
		op = ins[6:0];
		rd = ins[11:7];
		f3 = ins[14:12];
		f7 = ins[31:25];
		a = get_reg(ins[19:15]);
		b = get_reg(ins[24:20]);
		immi = {{20{ins[31]}}, ins[31:20]};
		case (op)
			rv32x_pkg::OP_REG: begin
				if (f7 != 0 && !(f7 == rv32x_pkg::F7_ALT && (f3 == 0 || f3 == 5)))
					return rv32x_pkg::FLT_FUNCT7;
				put_reg(rd, alu_calc(f3, f7 == rv32x_pkg::F7_ALT, a, b));
				pc_q = pc_q + 4;
			end
			rv32x_pkg::OP_IMM: begin
				if (f3 == 1 && f7 != 0) return rv32x_pkg::FLT_FUNCT7;
				if (f3 == 5 && f7 != 0 && f7 != rv32x_pkg::F7_ALT)
					return rv32x_pkg::FLT_FUNCT7;
				put_reg(rd, alu_calc(f3, f3 == 5 && f7 == rv32x_pkg::F7_ALT, a, immi));
				pc_q = pc_q + 4;
			end
			rv32x_pkg::OP_LUI: begin
				put_reg(rd, {ins[31:12], 12'd0});
				pc_q = pc_q + 4;
			end
			rv32x_pkg::OP_AUIPC: begin
				put_reg(rd, pc_q + {ins[31:12], 12'd0});
				pc_q = pc_q + 4;
			end
			rv32x_pkg::OP_BRANCH: begin
				imm = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
				case (f3)
					3'd0: take = a == b;
					3'd1: take = a != b;
					3'd4: take = $signed(a) < $signed(b);
					3'd5: take = $signed(a) >= $signed(b);
					3'd6: take = a < b;
					3'd7: take = a >= b;
					default: return rv32x_pkg::FLT_FUNCT3;
				endcase
				pc_q = take ? pc_q + imm : pc_q + 4;
			end
			rv32x_pkg::OP_JAL: begin
				imm = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
				put_reg(rd, pc_q + 4);
				pc_q = pc_q + imm;
			end
			rv32x_pkg::OP_JALR: begin
				if (f3 != 0) return rv32x_pkg::FLT_FUNCT3;
				addr = (a + immi) & ~32'd1;
				put_reg(rd, pc_q + 4);
				pc_q = addr;
			end
			rv32x_pkg::OP_LOAD: begin
				if (!w.perm_read) return rv32x_pkg::FLT_NO_RD;
				if (f3 == 3 || f3 > 5) return rv32x_pkg::FLT_FUNCT3;
				ld_busy = 1;
				ld_dest = rd;
				ld_size = f3[1:0];
				ld_sext = f3 < 4;
				pred.result_kind = rv32x_pkg::KIND_LOAD;
				pred.mem_address = a + immi;
				pred.access_size = f3[1:0];
				pc_q = pc_q + 4;
			end
			rv32x_pkg::OP_STORE: begin
				imm = {{20{ins[31]}}, ins[31:25], ins[11:7]};
				if (!w.perm_write) return rv32x_pkg::FLT_NO_WR;
				if (f3 > 2) return rv32x_pkg::FLT_FUNCT3;
				pred.result_kind = rv32x_pkg::KIND_STORE;
				pred.mem_address = a + imm;
				pred.access_size = f3[1:0];
				pred.store_data = b;
				pc_q = pc_q + 4;
			end
			default: return rv32x_pkg::FLT_OPCODE;
		endcase
		return rv32x_pkg::FLT_NONE;
	endfunction

	function automatic rv32x_pkg::out_word_t predict_result(rv32x_pkg::in_word_t w);
		logic [2:0]  code;
		logic [31:0] v;
		pred = '0;
		if (w.action == rv32x_pkg::ACT_SET_PC) begin
			pc_q = w.value;
			halted_q = 0;
			halt_q = rv32x_pkg::FLT_NONE;
			ld_busy = 0;
		end else if (w.action == rv32x_pkg::ACT_RESERVED) begin
			pred.result_kind = rv32x_pkg::KIND_IGNORED;
		end else if (halted_q) begin
			pred.result_kind = rv32x_pkg::KIND_IGNORED;
			pred.fault_code = halt_q;
		end else if (w.action == rv32x_pkg::ACT_LOAD) begin
			if (!ld_busy) begin
				pred.result_kind = rv32x_pkg::KIND_IGNORED;
			end else begin
				if (ld_size == rv32x_pkg::SIZE_BYTE)
					v = ld_sext ? {{24{w.value[7]}}, w.value[7:0]} : {24'd0, w.value[7:0]};
				else if (ld_size == rv32x_pkg::SIZE_HALF)
					v = ld_sext ? {{16{w.value[15]}}, w.value[15:0]} : {16'd0, w.value[15:0]};
				else
					v = w.value;
				pred.access_size = ld_size;
				put_reg(ld_dest, v);
				ld_busy = 0;
			end
		end else if (ld_busy) begin
			pred.result_kind = rv32x_pkg::KIND_IGNORED;
		end else begin
			code = run_instr(w);
			if (code != rv32x_pkg::FLT_NONE) begin
				pred = '0;
				pred.result_kind = rv32x_pkg::KIND_FAULT;
				pred.fault_code = code;
				halted_q = 1;
				halt_q = code;
			end
		end
		pred.pc_now = pc_q;
		return pred;
	endfunction

	function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
		return {f7, rs2, rs1, f3, rd, op};
	endfunction

	function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
			logic [4:0] rd, logic [6:0] op);
		return {imm, rs1, f3, rd, op};
	endfunction

	task automatic add_word(logic [1:0] act, logic [31:0] ins, logic [31:0] val,
			logic pr = 1, logic pw = 1, bit drain = 0);
		stim_t s;
		s.w.action = act;
		s.w.instruction = ins;
		s.w.value = val;
		s.w.perm_read = pr;
		s.w.perm_write = pw;
		s.drain = drain;
		stim_q.push_back(s);
	endtask

	task automatic add_exec(logic [31:0] ins, logic pr = 1, logic pw = 1);
		add_word(rv32x_pkg::ACT_EXEC, ins, $urandom, pr, pw);
	endtask

	function automatic logic [4:0] rnd_reg();
		return ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
	endfunction

	// well-formed instruction of a random class
	task automatic add_random_legal();
		logic [2:0] f3;
		logic [6:0] f7;
		case ($urandom_range(0, 9))
			0: begin
				f3 = 3'($urandom);
				f7 = ((f3 == 0 || f3 == 5) && $urandom_range(0, 1)) ? rv32x_pkg::F7_ALT : 7'd0;
				add_exec(enc_r(f7, rnd_reg(), rnd_reg(), f3, rnd_reg(), rv32x_pkg::OP_REG));
			end
			1, 2: begin
				f3 = 3'($urandom);
				f7 = (f3 == 1) ? 7'd0 :
					(f3 == 5) ? ($urandom_range(0, 1) ? rv32x_pkg::F7_ALT : 7'd0) :
					7'($urandom);
				add_exec(enc_r(f7, 5'($urandom), rnd_reg(), f3, rnd_reg(), rv32x_pkg::OP_IMM));
			end
			3: add_exec({20'($urandom), rnd_reg(),
				$urandom_range(0, 1) ? rv32x_pkg::OP_LUI : rv32x_pkg::OP_AUIPC});
			4: begin
				f3 = 3'($urandom_range(0, 5));
				if (f3 >= 2) f3 = f3 + 3'd2;
				add_exec(enc_r(7'($urandom), rnd_reg(), rnd_reg(), f3, 5'($urandom),
					rv32x_pkg::OP_BRANCH));
			end
			5: add_exec({20'($urandom), rnd_reg(), rv32x_pkg::OP_JAL});
			6: add_exec(enc_i(12'($urandom), rnd_reg(), 3'd0, rnd_reg(), rv32x_pkg::OP_JALR));
			7, 8: begin
				f3 = 3'($urandom_range(0, 4));
				if (f3 == 3) f3 = 3'd5;
				add_exec(enc_i(12'($urandom), rnd_reg(), f3, rnd_reg(), rv32x_pkg::OP_LOAD));
				add_word(rv32x_pkg::ACT_LOAD, $urandom, $urandom);
			end
			default: add_exec(enc_r(7'($urandom), rnd_reg(), rnd_reg(),
				3'($urandom_range(0, 2)), 5'($urandom), rv32x_pkg::OP_STORE));
		endcase
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch word %0d %s: got %h expected %h", n_words, what, got, want);
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !took_in) begin
			end else if (in_gap > 0) begin
				in_gap--;
				in_valid <= 0;
			end else if (stim_q.size() > 0 && !(stim_q[0].drain && exp_q.size() != 0)) begin
				in_valid <= 1;
				in_data <= stim_q[0].w;
				stim_q.pop_front();
				in_gap = idle_on ? $urandom_range(0, 5) : 0;
			end else begin
				in_valid <= 0;
			end
		end
	end

	always @(posedge clk) begin
		took_in = in_valid && in_ready;
		if (took_in) begin
			exp_q.push_back(predict_result(in_data));
			if (++quiet == 64) begin
				quiet = 0;
				idle_on = $urandom_range(0, 3) != 0;
			end
		end
	end

	// receiver side
	always @(negedge clk) begin
		if (arst_n) begin
			if (n_words >= 400 && !did_stall) begin
				did_stall = 1;
				stall_left = STALL_LEN;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 0;
			end else if (out_gap > 0) begin
				out_gap--;
				out_ready <= 0;
			end else begin
				out_ready <= 1;
				if (out_valid) out_gap = idle_on ? $urandom_range(0, 5) : 0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		rv32x_pkg::out_word_t e;
		if (out_valid && out_ready) begin
			n_words++;
			if (exp_q.size() == 0) begin
				report_mismatch("unexpected result", 32'(out_data.result_kind), 32'd0);
			end else begin
				e = exp_q.pop_front();
				case (e.result_kind)
					rv32x_pkg::KIND_LOAD: n_loads++;
					rv32x_pkg::KIND_STORE: n_stores++;
					rv32x_pkg::KIND_FAULT: n_faults++;
					rv32x_pkg::KIND_IGNORED: n_ignored++;
					default: ;
				endcase
				if (out_data.result_kind != e.result_kind)
					report_mismatch("result_kind", 32'(out_data.result_kind), 32'(e.result_kind));
				if (out_data.mem_address != e.mem_address)
					report_mismatch("mem_address", out_data.mem_address, e.mem_address);
				if (out_data.access_size != e.access_size)
					report_mismatch("access_size", 32'(out_data.access_size), 32'(e.access_size));
				if (out_data.store_data != e.store_data)
					report_mismatch("store_data", out_data.store_data, e.store_data);
				if (out_data.fault_code != e.fault_code)
					report_mismatch("fault_code", 32'(out_data.fault_code), 32'(e.fault_code));
				if (out_data.pc_now != e.pc_now)
					report_mismatch("pc_now", out_data.pc_now, e.pc_now);
				if (out_data.reg_written != e.reg_written)
					report_mismatch("reg_written", 32'(out_data.reg_written), 32'(e.reg_written));
				if (out_data.reg_index != e.reg_index)
					report_mismatch("reg_index", 32'(out_data.reg_index), 32'(e.reg_index));
				if (out_data.reg_value != e.reg_value)
					report_mismatch("reg_value", out_data.reg_value, e.reg_value);
			end
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		int idle_cycles;
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		out_ready = 0;

		// directed part
		add_exec(enc_i(12'hFFF, 5'd0, 3'd0, 5'd1, rv32x_pkg::OP_IMM));         // x1 = -1
		add_exec({20'h80000, 5'd2, rv32x_pkg::OP_LUI});                         // x2 = min int
		add_exec({20'hFFFFF, 5'd3, rv32x_pkg::OP_AUIPC});
		for (int f = 0; f < 8; f++)
			add_exec(enc_r(7'd0, 5'd2, 5'd1, 3'(f), 5'(4 + f), rv32x_pkg::OP_REG));
		add_exec(enc_r(rv32x_pkg::F7_ALT, 5'd1, 5'd2, 3'd0, 5'd12, rv32x_pkg::OP_REG)); // sub
		add_exec(enc_r(rv32x_pkg::F7_ALT, 5'd1, 5'd2, 3'd5, 5'd13, rv32x_pkg::OP_REG)); // sra 31
		add_exec(enc_r(rv32x_pkg::F7_ALT, 5'd31, 5'd2, 3'd5, 5'd14, rv32x_pkg::OP_IMM)); // srai
		add_exec(enc_r(7'd0, 5'd1, 5'd1, 3'd1, 5'd31, rv32x_pkg::OP_BRANCH));   // bne not taken
		add_exec(enc_r(7'h7F, 5'd1, 5'd2, 3'd4, 5'd31, rv32x_pkg::OP_BRANCH));  // blt taken, back
		add_exec({1'b1, 10'h3FF, 1'b1, 8'hFF, 5'd15, rv32x_pkg::OP_JAL});
		add_exec(enc_i(12'h7FF, 5'd1, 3'd0, 5'd1, rv32x_pkg::OP_JALR));        // rs1 == rd
		add_exec(enc_i(12'h000, 5'd1, 3'd0, 5'd16, rv32x_pkg::OP_LOAD));
		add_word(rv32x_pkg::ACT_LOAD, '0, 32'h0000_0080);
		add_exec(enc_i(12'h004, 5'd1, 3'd5, 5'd17, rv32x_pkg::OP_LOAD));
		add_exec(enc_i(12'h0, 5'd0, 3'd0, 5'd1, rv32x_pkg::OP_IMM));            // load pending
		add_word(rv32x_pkg::ACT_LOAD, '0, 32'hFFFF_8001);
		add_word(rv32x_pkg::ACT_LOAD, '0, 32'h1234_5678);                       // stray return
		add_word(rv32x_pkg::ACT_RESERVED, '1, '1);
		add_exec(enc_r(7'h7F, 5'd1, 5'd2, 3'd2, 5'h1F, rv32x_pkg::OP_STORE));
		add_exec(enc_r(7'd0, 5'd1, 5'd2, 3'd2, 5'd0, rv32x_pkg::OP_STORE), 1, 0); // no write
		add_exec(enc_i(12'h0, 5'd2, 3'd1, 5'd3, rv32x_pkg::OP_IMM));            // while halted
		add_word(rv32x_pkg::ACT_SET_PC, '0, 32'hFFFF_FFFC);
		add_exec(enc_i(12'h0, 5'd2, 3'd0, 5'd3, rv32x_pkg::OP_LOAD), 0, 1);     // no read
		add_word(rv32x_pkg::ACT_SET_PC, '0, 32'h0000_1000);
		add_exec(enc_i(12'h0, 5'd1, 3'd1, 5'd3, rv32x_pkg::OP_JALR));
		add_word(rv32x_pkg::ACT_SET_PC, '0, '0);
		add_exec(enc_r(7'h01, 5'd1, 5'd2, 3'd0, 5'd3, rv32x_pkg::OP_REG));
		add_word(rv32x_pkg::ACT_SET_PC, '0, 32'h0000_0100);
		add_exec(32'hFFFF_FFFF);                                                 // bad opcode
		add_word(rv32x_pkg::ACT_SET_PC, '0, 32'h0000_0200);

		// random part: mostly legal code, some noise and broken sequences
		while (stim_q.size() < 1050) begin
			case ($urandom_range(0, 19))
				0: add_word(2'($urandom), $urandom, $urandom, 1'($urandom), 1'($urandom));
				1: add_word(rv32x_pkg::ACT_SET_PC, $urandom, $urandom, 1'($urandom),
					1'($urandom));
				2: add_exec($urandom, 1'($urandom), 1'($urandom));
				default: add_random_legal();
			endcase
			if ($urandom_range(0, 9) == 0) add_word(rv32x_pkg::ACT_SET_PC, '0, $urandom);
			if (stim_q.size() >= 600 && stim_q.size() < 603) begin
				add_word(rv32x_pkg::ACT_SET_PC, '0, 32'h0000_4000, 1, 1, 1);
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		while (stim_q.size() != 0 || in_valid || exp_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d results checked: %0d loads, %0d stores, %0d faults, %0d ignored",
			n_words, n_loads, n_stores, n_faults, n_ignored);
		$display("covered alu, branch, jump, load/store, halt and set_pc paths under stalls");
		if (errors == 0 && exp_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/rv32x_pkg.sv
rtl/rv32x_exec.sv
rtl/rv32i_integer_execute_core.sv
rtl/rv32x_checker.sv
tb/tb_rv32i_integer_execute_core.sv
